/* rtl/wps_pkg.sv */
package wps_pkg;

  typedef enum logic [2:0] {
    STEP_IDLE     = 3'd0,
    STEP_GPS_ON   = 3'd1,
    STEP_GPS_WAIT = 3'd2,
    STEP_UART     = 3'd3,
    STEP_SIM_WAKE = 3'd4,
    STEP_DONE     = 3'd5
  } step_t;

  typedef enum logic [1:0] {
    CMD_STEP  = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  localparam int unsigned ADDR_W = 4;

  typedef enum logic [1:0] {
    REG_GPS_FIX_TIMEOUT   = 2'd0,
    REG_MODEM_READY_TMO   = 2'd1,
    REG_WAKE_WINDOW       = 2'd2,
    REG_DEFAULT_WINDOW    = 2'd3
  } reg_idx_t;

  localparam logic [31:0] GPS_FIX_TIMEOUT_RST = 32'd60000;
  localparam logic [31:0] MODEM_READY_TMO_RST = 32'd90000;
  localparam logic [31:0] WAKE_WINDOW_RST     = 32'd0;
  localparam logic [31:0] DEFAULT_WINDOW_RST  = 32'd300000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] elapsed_ms;
    logic        gps_fix;
    logic        modem_busy;
    logic        modem_ready;
  } cmd_item_t;

  typedef struct packed {
    logic       gps_power_pulse;
    logic       modem_power_pulse;
    logic       modem_start_pulse;
    logic       modem_hard_reset_pulse;
    logic       sequence_done;
    logic       window_expired;
    logic [2:0] current_step;
  } res_item_t;

  typedef struct packed {
    logic [31:0] gps_fix_timeout_ms;
    logic [31:0] modem_ready_timeout_ms;
    logic [31:0] wake_window_ms;
    logic [31:0] default_window_ms;
  } cfg_t;

  typedef struct packed {
    step_t       step;
    logic [31:0] gps_wait_elapsed;
    logic [31:0] modem_wait_elapsed;
    logic [31:0] window_elapsed;
    logic        start_already_sent;
  } seq_state_t;

endpackage

/* rtl/wake_power_sequencer.sv */
// A result is registered into the output register once its command item is accepted,
// and is held back only while the result channel is stalled.
// Throughput: one item per cycle unless cmd_stall is high; the whole state update is
// a single pass of saturating adds and compares between state and result registers.
// A two-entry result buffer lets the input take one more item after the output stalls.
// Reset (rst, synchronous) returns the sequence to idle, clears all elapsed
// counters and loads the configuration registers with their default values.
module wake_power_sequencer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_valid,
  output logic                        cmd_stall,
  input  wps_pkg::cmd_item_t          cmd_item,
  output logic                        res_valid,
  input  logic                        res_stall,
  output wps_pkg::res_item_t          res_item,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wps_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  wps_pkg::cfg_t       cfg;
  wps_pkg::seq_state_t seq;
  wps_pkg::seq_state_t seq_next;
  wps_pkg::res_item_t  result;
  wps_pkg::res_item_t  skid_item;
  logic                skid_valid;
  logic                accept;
  logic                out_free;
  logic                cfg_write;
  wps_pkg::reg_idx_t   reg_idx;

  assign pready    = 1'b1;
  assign reg_idx   = wps_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;
  assign cmd_stall = skid_valid;
  assign accept    = cmd_valid && !cmd_stall;
  assign out_free  = !res_valid || !res_stall;

  wps_step u_step (
    .cfg     (cfg),
    .st      (seq),
    .item    (cmd_item),
    .st_next (seq_next),
    .res     (result)
  );

  always_comb begin
    case (reg_idx)
      wps_pkg::REG_GPS_FIX_TIMEOUT: prdata = cfg.gps_fix_timeout_ms;
      wps_pkg::REG_MODEM_READY_TMO: prdata = cfg.modem_ready_timeout_ms;
      wps_pkg::REG_WAKE_WINDOW:     prdata = cfg.wake_window_ms;
      wps_pkg::REG_DEFAULT_WINDOW:  prdata = cfg.default_window_ms;
      default:                      prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gps_fix_timeout_ms     <= wps_pkg::GPS_FIX_TIMEOUT_RST;
      cfg.modem_ready_timeout_ms <= wps_pkg::MODEM_READY_TMO_RST;
      cfg.wake_window_ms         <= wps_pkg::WAKE_WINDOW_RST;
      cfg.default_window_ms      <= wps_pkg::DEFAULT_WINDOW_RST;
    end else if (cfg_write) begin
      case (reg_idx)
        wps_pkg::REG_GPS_FIX_TIMEOUT: cfg.gps_fix_timeout_ms     <= pwdata;
        wps_pkg::REG_MODEM_READY_TMO: cfg.modem_ready_timeout_ms <= pwdata;
        wps_pkg::REG_WAKE_WINDOW:     cfg.wake_window_ms         <= pwdata;
        wps_pkg::REG_DEFAULT_WINDOW:  cfg.default_window_ms      <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq.step               <= wps_pkg::STEP_IDLE;
      seq.gps_wait_elapsed   <= 32'd0;
      seq.modem_wait_elapsed <= 32'd0;
      seq.window_elapsed     <= 32'd0;
      seq.start_already_sent <= 1'b0;
    end else if (accept) begin
      seq <= seq_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      res_valid  <= skid_valid || accept;
      skid_valid <= 1'b0;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      res_item <= skid_valid ? skid_item : result;
    end
    if (!out_free && accept) begin
      skid_item <= result;
    end
  end

  a_skid_needs_output: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> res_valid)
    else $error("skid entry held while the output register is empty");

  a_clear_to_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd_item.cmd == wps_pkg::CMD_CLEAR) |=> seq.step == wps_pkg::STEP_IDLE)
    else $error("clear command did not return the sequence to idle");

  a_hard_reset_in_sim: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_item.modem_hard_reset_pulse) |->
      res_item.current_step == wps_pkg::STEP_SIM_WAKE)
    else $error("hard reset pulse outside SIM wake");

  a_done_matches_step: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_item.sequence_done == (res_item.current_step == wps_pkg::STEP_DONE)))
    else $error("sequence_done disagrees with current_step");

endmodule

/* rtl/wps_step.sv */
module wps_step (
  input  wps_pkg::cfg_t       cfg,
  input  wps_pkg::seq_state_t st,
  input  wps_pkg::cmd_item_t  item,
  output wps_pkg::seq_state_t st_next,
  output wps_pkg::res_item_t  res
);

  logic [32:0] gps_raw;
  logic [32:0] modem_raw;
  logic [32:0] win_raw;
  logic [31:0] gps_sum;
  logic [31:0] modem_sum;
  logic [31:0] win_sum;
  logic [31:0] win_limit;
  logic        gps_timeout;
  logic        modem_timeout;
  logic        is_step;

  assign gps_raw   = {1'b0, st.gps_wait_elapsed} + {17'd0, item.elapsed_ms};
  assign modem_raw = {1'b0, st.modem_wait_elapsed} + {17'd0, item.elapsed_ms};
  assign win_raw   = {1'b0, st.window_elapsed} + {17'd0, item.elapsed_ms};

  // Elapsed counters saturate at all ones.
  assign gps_sum   = gps_raw[32] ? '1 : gps_raw[31:0];
  assign modem_sum = modem_raw[32] ? '1 : modem_raw[31:0];
  assign win_sum   = win_raw[32] ? '1 : win_raw[31:0];

  assign win_limit = (cfg.wake_window_ms != 32'd0) ? cfg.wake_window_ms
                                                    : cfg.default_window_ms;
  assign gps_timeout   = gps_sum >= cfg.gps_fix_timeout_ms;
  assign modem_timeout = modem_sum >= cfg.modem_ready_timeout_ms;
  assign is_step       = item.cmd == wps_pkg::CMD_STEP;

  always_comb begin
    st_next = st;
    case (wps_pkg::cmd_t'(item.cmd))
      wps_pkg::CMD_STEP: begin
        case (st.step)
          wps_pkg::STEP_IDLE: begin
            st_next.step = wps_pkg::STEP_GPS_ON;
          end
          wps_pkg::STEP_GPS_ON: begin
            st_next.gps_wait_elapsed = 32'd0;
            st_next.step             = wps_pkg::STEP_GPS_WAIT;
          end
          wps_pkg::STEP_GPS_WAIT: begin
            st_next.gps_wait_elapsed = gps_sum;
            if (item.gps_fix || gps_timeout) begin
              st_next.step = wps_pkg::STEP_UART;
            end
          end
          wps_pkg::STEP_UART: begin
            st_next.modem_wait_elapsed = 32'd0;
            st_next.start_already_sent = 1'b0;
            st_next.step               = wps_pkg::STEP_SIM_WAKE;
          end
          wps_pkg::STEP_SIM_WAKE: begin
            st_next.modem_wait_elapsed = modem_sum;
            if (!st.start_already_sent && !item.modem_busy) begin
              st_next.start_already_sent = 1'b1;
            end
            if (item.modem_ready) begin
              st_next.step = wps_pkg::STEP_DONE;
            end else if (modem_timeout) begin
              st_next.modem_wait_elapsed = 32'd0;
              st_next.start_already_sent = 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
      wps_pkg::CMD_TICK: begin
        st_next.window_elapsed = win_sum;
      end
      wps_pkg::CMD_CLEAR: begin
        st_next.step               = wps_pkg::STEP_IDLE;
        st_next.gps_wait_elapsed   = 32'd0;
        st_next.modem_wait_elapsed = 32'd0;
        st_next.window_elapsed     = 32'd0;
        st_next.start_already_sent = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.gps_power_pulse   = is_step && (st.step == wps_pkg::STEP_GPS_ON);
    res.modem_power_pulse = is_step && (st.step == wps_pkg::STEP_UART);
    res.modem_start_pulse = is_step && (st.step == wps_pkg::STEP_SIM_WAKE) &&
                            !st.start_already_sent && !item.modem_busy;
    res.modem_hard_reset_pulse = is_step && (st.step == wps_pkg::STEP_SIM_WAKE) &&
                                 !item.modem_ready && modem_timeout;
    res.sequence_done     = st_next.step == wps_pkg::STEP_DONE;
    res.window_expired    = (item.cmd == wps_pkg::CMD_TICK) && (win_sum >= win_limit);
    res.current_step      = st_next.step;
  end

endmodule

/* dv/tb_wake_power_sequencer.sv */
module tb_wake_power_sequencer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned HOLD_CYCLES = 60;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cmd_valid = 1'b0;
  logic                        cmd_stall;
  wps_pkg::cmd_item_t          cmd_item = '0;
  logic                        res_valid;
  logic                        res_stall = 1'b0;
  wps_pkg::res_item_t          res_item;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [wps_pkg::ADDR_W-1:0]  paddr = '0;
  logic [31:0]                 pwdata = '0;
  logic [31:0]                 prdata;
  logic                        pready;

  wps_pkg::cmd_item_t          cmd_backlog[$];
  wps_pkg::res_item_t          predicted_res[$];
  int unsigned                 send_idle_pct = 0;
  int unsigned                 recv_stall_pct = 0;
  logic                        hold_active = 1'b0;
  int unsigned                 error_count = 0;
  int unsigned                 idle_cycles = 0;
  int unsigned                 queued_count = 0;

  wps_pkg::cfg_t               shadow_cfg = '{wps_pkg::GPS_FIX_TIMEOUT_RST,
                                              wps_pkg::MODEM_READY_TMO_RST,
                                              wps_pkg::WAKE_WINDOW_RST,
                                              wps_pkg::DEFAULT_WINDOW_RST};
  wps_pkg::step_t              seq_step = wps_pkg::STEP_IDLE;
  logic [31:0]                 gps_ms = '0;
  logic [31:0]                 modem_ms = '0;
  logic [31:0]                 window_ms = '0;
  logic                        start_sent = 1'b0;

  wake_power_sequencer u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_item  (cmd_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #2 clk = ~clk;

  function automatic logic [31:0] add_sat(logic [31:0] a, logic [15:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {17'd0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic wps_pkg::res_item_t advance_sequence(wps_pkg::cmd_item_t it);
    wps_pkg::res_item_t r;
    logic [31:0]        limit;
    r = '0;
    case (it.cmd)
      wps_pkg::CMD_STEP: begin
        case (seq_step)
          wps_pkg::STEP_IDLE: seq_step = wps_pkg::STEP_GPS_ON;
          wps_pkg::STEP_GPS_ON: begin
            r.gps_power_pulse = 1'b1;
            gps_ms = '0;
            seq_step = wps_pkg::STEP_GPS_WAIT;
          end
          wps_pkg::STEP_GPS_WAIT: begin
            gps_ms = add_sat(gps_ms, it.elapsed_ms);
            if (it.gps_fix || gps_ms >= shadow_cfg.gps_fix_timeout_ms) begin
              seq_step = wps_pkg::STEP_UART;
            end
          end
          wps_pkg::STEP_UART: begin
            r.modem_power_pulse = 1'b1;
            modem_ms = '0;
            start_sent = 1'b0;
            seq_step = wps_pkg::STEP_SIM_WAKE;
          end
          wps_pkg::STEP_SIM_WAKE: begin
            modem_ms = add_sat(modem_ms, it.elapsed_ms);
            if (!start_sent && !it.modem_busy) begin
              r.modem_start_pulse = 1'b1;
              start_sent = 1'b1;
            end
            if (it.modem_ready) begin
              seq_step = wps_pkg::STEP_DONE;
            end else if (modem_ms >= shadow_cfg.modem_ready_timeout_ms) begin
              modem_ms = '0;
              start_sent = 1'b0;
              r.modem_hard_reset_pulse = 1'b1;
            end
          end
          default: ;
        endcase
      end
      wps_pkg::CMD_TICK: begin
        limit = (shadow_cfg.wake_window_ms != '0) ? shadow_cfg.wake_window_ms
                                                   : shadow_cfg.default_window_ms;
        window_ms = add_sat(window_ms, it.elapsed_ms);
        r.window_expired = (window_ms >= limit);
      end
      wps_pkg::CMD_CLEAR: begin
        seq_step = wps_pkg::STEP_IDLE;
        gps_ms = '0;
        modem_ms = '0;
        window_ms = '0;
        start_sent = 1'b0;
      end
      default: ;
    endcase
    r.sequence_done = (seq_step == wps_pkg::STEP_DONE);
    r.current_step = seq_step;
    return r;
  endfunction

  task automatic check_result(wps_pkg::res_item_t got);
    wps_pkg::res_item_t want;
    if (predicted_res.size() == 0) begin
      $display("%0t: result expected none got %0h", $time, got);
      error_count++;
    end else begin
      want = predicted_res.pop_front();
      if (want !== got) begin
        $display("%0t: result expected %0h got %0h", $time, want, got);
        error_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && !cmd_stall) begin
        predicted_res.push_back(advance_sequence(cmd_item));
      end
      if (!cmd_valid || !cmd_stall) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cmd_item <= cmd_backlog.pop_front();
          cmd_valid <= 1'b1;
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        check_result(res_item);
      end
      res_stall <= hold_active || ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic wps_pkg::cmd_item_t make_cmd(wps_pkg::cmd_t c, logic [15:0] d,
                                                  logic fix, logic busy, logic ready);
    wps_pkg::cmd_item_t it;
    it.cmd = c;
    it.elapsed_ms = d;
    it.gps_fix = fix;
    it.modem_busy = busy;
    it.modem_ready = ready;
    return it;
  endfunction

  function automatic logic [15:0] pick_delta();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3: return 16'($urandom_range(1, 100));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_cmd(wps_pkg::cmd_item_t it);
    cmd_backlog.push_back(it);
    queued_count++;
  endtask

  task automatic queue_step(logic fix, logic busy, logic ready);
    if ($urandom_range(4) == 0) begin
      queue_cmd(make_cmd(wps_pkg::CMD_TICK, pick_delta(), 1'($urandom), 1'($urandom),
                         1'($urandom)));
    end
    queue_cmd(make_cmd(wps_pkg::CMD_STEP, pick_delta(), fix, busy, ready));
  endtask

  task automatic queue_wake_cycle();
    int unsigned n;
    queue_cmd(make_cmd(wps_pkg::CMD_CLEAR, pick_delta(), 1'($urandom), 1'($urandom),
                       1'($urandom)));
    queue_step(1'($urandom), 1'($urandom), 1'($urandom));
    queue_step(1'($urandom), 1'($urandom), 1'($urandom));
    n = $urandom_range(0, 4);
    repeat (n) queue_step(1'b0, 1'($urandom), 1'($urandom));
    queue_step(1'($urandom), 1'($urandom), 1'($urandom));
    queue_step(1'($urandom), 1'($urandom), 1'($urandom));
    n = $urandom_range(0, 6);
    repeat (n) queue_step(1'($urandom), 1'($urandom), 1'b0);
    if ($urandom_range(3) != 0) begin
      queue_step(1'($urandom), 1'($urandom), 1'b1);
    end
    n = $urandom_range(0, 2);
    repeat (n) queue_step(1'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic queue_random(int unsigned n);
    int unsigned stop_at;
    stop_at = queued_count + n;
    while (queued_count < stop_at) begin
      if ($urandom_range(9) == 0) begin
        queue_cmd(make_cmd(wps_pkg::cmd_t'($urandom_range(3)), 16'($urandom),
                           1'($urandom), 1'($urandom), 1'($urandom)));
      end else begin
        queue_wake_cycle();
      end
    end
  endtask

  task automatic wait_drained();
    while (cmd_backlog.size() != 0 || cmd_valid || predicted_res.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(wps_pkg::reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      wps_pkg::REG_GPS_FIX_TIMEOUT: shadow_cfg.gps_fix_timeout_ms = val;
      wps_pkg::REG_MODEM_READY_TMO: shadow_cfg.modem_ready_timeout_ms = val;
      wps_pkg::REG_WAKE_WINDOW:     shadow_cfg.wake_window_ms = val;
      wps_pkg::REG_DEFAULT_WINDOW:  shadow_cfg.default_window_ms = val;
      default: ;
    endcase
  endtask

  task automatic apply_config(logic [31:0] gps_tmo, logic [31:0] modem_tmo,
                              logic [31:0] window, logic [31:0] dflt_window);
    write_reg(wps_pkg::REG_GPS_FIX_TIMEOUT, gps_tmo);
    write_reg(wps_pkg::REG_MODEM_READY_TMO, modem_tmo);
    write_reg(wps_pkg::REG_WAKE_WINDOW, window);
    write_reg(wps_pkg::REG_DEFAULT_WINDOW, dflt_window);
  endtask

  task automatic run_random_phase(int unsigned idle_pct, int unsigned stall_pct,
                                  int unsigned n);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    queue_random(n);
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the whole sequence under the reset configuration, including fix and
    // timeout together, a hard reset and retry, and ready and timeout together.
    queue_cmd(make_cmd(wps_pkg::CMD_NONE, 16'hFFFF, 1'b1, 1'b1, 1'b1));
    queue_cmd(make_cmd(wps_pkg::CMD_TICK, 16'h0000, 1'b0, 1'b0, 1'b0));
    queue_cmd(make_cmd(wps_pkg::CMD_STEP, 16'h0000, 1'b0, 1'b0, 1'b0));
    queue_cmd(make_cmd(wps_pkg::CMD_STEP, 16'hFFFF, 1'b0, 1'b0, 1'b0));
    queue_cmd(make_cmd(wps_pkg::CMD_STEP, 16'd1000, 1'b0, 1'b1, 1'b1));
    queue_cmd(make_cmd(wps_pkg::CMD_STEP, 16'hFFFF, 1'b1, 1'b0, 1'b0));
    queue_cmd(make_cmd(wps_pkg::CMD_STEP, 16'h0000, 1'b0, 1'b0, 1'b0));
    queue_cmd(make_cmd(wps_pkg::CMD_STEP, 16'd100, 1'b0, 1'b1, 1'b0));
    queue_cmd(make_cmd(wps_pkg::CMD_STEP, 16'hFFFF, 1'b0, 1'b0, 1'b0));
    queue_cmd(make_cmd(wps_pkg::CMD_STEP, 16'hFFFF, 1'b0, 1'b0, 1'b0));
    queue_cmd(make_cmd(wps_pkg::CMD_STEP, 16'hFFFF, 1'b0, 1'b0, 1'b0));
    queue_cmd(make_cmd(wps_pkg::CMD_STEP, 16'hFFFF, 1'b0, 1'b0, 1'b1));
    queue_cmd(make_cmd(wps_pkg::CMD_STEP, 16'h0000, 1'b1, 1'b1, 1'b1));
    queue_cmd(make_cmd(wps_pkg::CMD_NONE, 16'h0000, 1'b0, 1'b0, 1'b0));
    repeat (5) queue_cmd(make_cmd(wps_pkg::CMD_TICK, 16'hFFFF, 1'b1, 1'b1, 1'b1));
    queue_cmd(make_cmd(wps_pkg::CMD_CLEAR, 16'hFFFF, 1'b1, 1'b1, 1'b1));
    queue_cmd(make_cmd(wps_pkg::CMD_STEP, 16'h0000, 1'b0, 1'b0, 1'b0));
    wait_drained();

    run_random_phase(0, 0, 150);

    apply_config(32'd0, 32'd0, 32'd0, 32'd0);
    run_random_phase(59, 0, 150);

    apply_config(32'd100000, 32'd150000, 32'd200000, 32'd5);
    run_random_phase(0, 59, 150);

    apply_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
    run_random_phase(8, 8, 150);

    // The receiver holds off while the sender keeps offering, so the block
    // fills up and stalls its input.
    apply_config($urandom_range(0, 200000), $urandom_range(0, 200000),
                 $urandom_range(0, 400000), $urandom_range(0, 400000));
    send_idle_pct = 0;
    recv_stall_pct = 0;
    queue_random(50);
    @(posedge clk);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active <= 1'b0;
    wait_drained();

    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
